@@ rtl/tkd_pkg.sv @@
// Shared types, byte codes and key tables for the terminal key escape decoder.
// No dependencies; tkd_decode, tkd_out_reg and the top level import this package.
package tkd_pkg;

  // Bytes that steer the parser
  localparam logic [7:0] ByteEsc   = 8'h1b;
  localparam logic [7:0] ByteCsi   = 8'h5b;  // '['
  localparam logic [7:0] ByteSs3   = 8'h4f;  // 'O'
  localparam logic [7:0] ByteTilde = 8'h7e;  // '~'
  localparam logic [7:0] ByteZero  = 8'h30;  // '0'
  localparam logic [7:0] ByteNine  = 8'h39;  // '9'

  // Input kinds carried on tuser
  localparam logic OpByte    = 1'b0;
  localparam logic OpTimeout = 1'b1;

  // Special key codes
  localparam logic [3:0] KeyLeft  = 4'd0;
  localparam logic [3:0] KeyRight = 4'd1;
  localparam logic [3:0] KeyUp    = 4'd2;
  localparam logic [3:0] KeyDown  = 4'd3;
  localparam logic [3:0] KeyDel   = 4'd4;
  localparam logic [3:0] KeyHome  = 4'd5;
  localparam logic [3:0] KeyEnd   = 4'd6;
  localparam logic [3:0] KeyPgUp  = 4'd7;
  localparam logic [3:0] KeyPgDn  = 4'd8;
  localparam logic [3:0] KeyNone  = 4'hf;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ESC,
    PH_FIRST,
    PH_DIGIT
  } phase_t;

  // One decoded result item
  typedef struct packed {
    logic       valid;
    logic       special;
    logic [7:0] value;
  } res_t;

  // Final letter of ESC [ x
  function automatic logic [3:0] map_csi_letter(input logic [7:0] b);
    logic [3:0] k;
    unique case (b)
      8'h41:   k = KeyUp;     // 'A'
      8'h42:   k = KeyDown;   // 'B'
      8'h43:   k = KeyRight;  // 'C'
      8'h44:   k = KeyLeft;   // 'D'
      8'h48:   k = KeyHome;   // 'H'
      8'h46:   k = KeyEnd;    // 'F'
      default: k = KeyNone;
    endcase
    return k;
  endfunction

  // Digit of ESC [ d ~
  function automatic logic [3:0] map_tilde_digit(input logic [7:0] d);
    logic [3:0] k;
    unique case (d)
      8'h31:   k = KeyHome;
      8'h33:   k = KeyDel;
      8'h34:   k = KeyEnd;
      8'h35:   k = KeyPgUp;
      8'h36:   k = KeyPgDn;
      8'h37:   k = KeyHome;
      8'h38:   k = KeyEnd;
      default: k = KeyNone;
    endcase
    return k;
  endfunction

endpackage

@@ rtl/tkd_decode.sv @@
// Escape sequence parser: phase FSM plus the held sequence bytes.
// Depends on tkd_pkg.
module tkd_decode (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,      // consume one item this cycle
  input  logic          opcode,
  input  logic [7:0]    byte_in,
  output tkd_pkg::res_t res
);
  import tkd_pkg::*;

  phase_t     phase, phase_next;
  logic [7:0] first_after_escape;
  logic [7:0] held_digit;
  logic       timeout;
  logic       is_digit;
  logic [3:0] key;

  assign timeout  = (opcode == OpTimeout);
  assign is_digit = (byte_in >= ByteZero) && (byte_in <= ByteNine);

  // next state
  always_comb begin
    phase_next = PH_IDLE;
    unique case (phase)
      PH_IDLE: begin
        if (!timeout && byte_in == ByteEsc) phase_next = PH_ESC;
      end
      PH_ESC: begin
        if (!timeout) phase_next = PH_FIRST;
      end
      PH_FIRST: begin
        if (!timeout && first_after_escape == ByteCsi && is_digit) phase_next = PH_DIGIT;
      end
      PH_DIGIT: phase_next = PH_IDLE;
      default:  phase_next = PH_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    key         = KeyNone;
    res.valid   = 1'b0;
    res.special = 1'b0;
    res.value   = ByteEsc;
    unique case (phase)
      PH_IDLE: begin
        if (!timeout && byte_in != ByteEsc) begin
          res.valid = 1'b1;
          res.value = byte_in;
        end
      end
      PH_ESC: begin
        res.valid = timeout;
      end
      PH_FIRST: begin
        if (timeout) begin
          res.valid = 1'b1;
        end else if (first_after_escape == ByteCsi) begin
          res.valid = !is_digit;
          key       = map_csi_letter(byte_in);
        end else begin
          res.valid = 1'b1;
          if (first_after_escape == ByteSs3 && byte_in == 8'h48) key = KeyHome;
          if (first_after_escape == ByteSs3 && byte_in == 8'h46) key = KeyEnd;
        end
        if (key != KeyNone) begin
          res.special = 1'b1;
          res.value   = {4'd0, key};
        end
      end
      PH_DIGIT: begin
        res.valid = 1'b1;
        if (!timeout && byte_in == ByteTilde) key = map_tilde_digit(held_digit);
        if (key != KeyNone) begin
          res.special = 1'b1;
          res.value   = {4'd0, key};
        end
      end
      default: res.valid = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else if (step) begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_after_escape <= 8'd0;
      held_digit         <= 8'd0;
    end else if (step) begin
      if (phase == PH_ESC && !timeout) first_after_escape <= byte_in;
      if (phase == PH_FIRST && !timeout && first_after_escape == ByteCsi && is_digit)
        held_digit <= byte_in;
    end
  end

endmodule

@@ rtl/tkd_out_reg.sv @@
// Result register on the master side; loads a decoded item, holds it until taken.
// Depends on tkd_pkg.
module tkd_out_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  tkd_pkg::res_t res,
  input  logic          take,     // downstream ready
  output logic          free,     // can load this cycle
  output logic          valid,
  output logic          special,
  output logic [7:0]    value
);
  import tkd_pkg::*;

  assign free = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (free) begin
      valid <= load && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load && res.valid) begin
      special <= res.special;
      value   <= res.value;
    end
  end

endmodule

@@ rtl/terminal_key_escape_decoder_core.sv @@
// Top level of the terminal key escape decoder: input register, parser, result register.
// Depends on tkd_pkg, tkd_decode and tkd_out_reg.
//
// Decodes a stream of terminal bytes into plain bytes and special keys (arrows, home,
// end, delete, page up/down) from VT100/ANSI sequences ESC [ A/B/C/D/H/F, ESC O H/F
// and ESC [ digit ~. Each input transaction is a received byte (tuser 0) or a read
// timeout (tuser 1). A timeout or an unknown byte inside a sequence yields one plain
// ESC and drops the bytes taken so far; a timeout outside a sequence yields nothing.
// One transaction is accepted every clock cycle while not stalled; a result reaches the
// master side through the input register, then the result register. Backpressure on the
// master side stalls the slave side only when both registers hold items.
module terminal_key_escape_decoder_core (
  input  logic       clk,
  input  logic       rst,
  // slave side
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] byte_in
  input  logic       s_tuser,   // [0] opcode (0 byte, 1 timeout)
  // master side
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] key_value
  output logic       m_tuser    // [0] is_special
);
  import tkd_pkg::*;

  // input register
  logic       in_valid;
  logic       in_opcode;
  logic [7:0] in_byte;
  logic       out_free;
  logic       advance;
  res_t       res;

  // the parser steps when the held item can move on into the result register
  assign advance  = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_opcode <= s_tuser;
      in_byte   <= s_tdata;
    end
  end

  tkd_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .opcode  (in_opcode),
    .byte_in (in_byte),
    .res     (res)
  );

  tkd_out_reg u_out (
    .clk     (clk),
    .rst     (rst),
    .load    (advance),
    .res     (res),
    .take    (m_tready),
    .free    (out_free),
    .valid   (m_tvalid),
    .special (m_tuser),
    .value   (m_tdata)
  );

endmodule

@@ rtl/tkd_checker.sv @@
// Port-level checks for the terminal key escape decoder, bound to the top level.
// Depends on terminal_key_escape_decoder_core.
module tkd_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic [7:0] s_tdata,
  input logic       s_tuser,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tuser
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // nothing shown right after reset
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // special key codes stay in range
  a_key: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata <= 8'd8)
    else $error("special key code out of range");

  // with an empty result register the slave side is always ready
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("stalled input with empty output");

endmodule

bind terminal_key_escape_decoder_core tkd_checker u_tkd_checker (.*);

@@ sim/terminal_key_escape_decoder_core_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for terminal_key_escape_decoder_core: predicts each key result
// in-line and checks the master side against it. Depends on tkd_pkg and the core rtl.
module terminal_key_escape_decoder_core_tb;
  import tkd_pkg::*;

  localparam int unsigned RANDOM_BYTES = 1350;
  localparam int unsigned STALL_LIMIT  = 2000;  // cycles with no transaction on either side
  localparam int unsigned TAIL_CYCLES  = 10;
  localparam int unsigned HOLD_CYCLES  = 250;   // long master-side hold-off
  localparam int unsigned HOLD_AT      = 300;   // result count that triggers the hold-off
  localparam logic [7:0]  CSI_FINALS [6] = '{"A", "B", "C", "D", "H", "F"};

  // one slave-side transaction, with the idle gap that follows it
  typedef struct {
    logic        timeout;
    logic [7:0]  data;
    int unsigned gap;
    bit          drain;  // hold this one back until no key result is outstanding
  } term_in_t;

  typedef struct packed {
    logic       special;
    logic [7:0] value;
  } key_res_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       s_tuser = OpByte;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tuser;

  term_in_t    pend_q[$];
  key_res_t    key_q[$];
  term_in_t    cur_item;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  int unsigned results_seen = 0;
  int unsigned idle_cycles = 0;
  bit          failed = 1'b0;
  bit          tx_calm = 1'b0;
  bit          rx_calm_done = 1'b0;
  bit          drain_next = 1'b0;
  logic        pred_spec;
  logic [7:0]  pred_val;

  // predictor state
  phase_t     parse_ph = PH_IDLE;
  logic [7:0] esc_next_byte = 8'h00;
  logic [7:0] seq_digit = 8'h00;

  terminal_key_escape_decoder_core dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // mostly back-to-back, sometimes a few cycles, rarely a long pause
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    else if (r < 88) return $urandom_range(3, 1);
    else if (r < 97) return $urandom_range(12, 4);
    else return $urandom_range(60, 20);
  endfunction

  function automatic logic [3:0] csi_final_key(input logic [7:0] b);
    case (b)
      "A":     return KeyUp;
      "B":     return KeyDown;
      "C":     return KeyRight;
      "D":     return KeyLeft;
      "H":     return KeyHome;
      "F":     return KeyEnd;
      default: return KeyNone;
    endcase
  endfunction

  function automatic logic [3:0] tilde_key(input logic [7:0] d);
    case (d)
      "1", "7": return KeyHome;
      "4", "8": return KeyEnd;
      "3":      return KeyDel;
      "5":      return KeyPgUp;
      "6":      return KeyPgDn;
      default:  return KeyNone;
    endcase
  endfunction

  // Advances the parser by one transaction; returns 1 when it yields a key result.
  // Any abandoned sequence collapses to a plain ESC.
  function automatic bit decode_key(input logic tmo, input logic [7:0] b,
                                    output logic spec, output logic [7:0] val);
    logic [3:0] key;
    spec = 1'b0;
    val  = ByteEsc;
    key  = KeyNone;
    case (parse_ph)
      PH_ESC: begin
        if (tmo) begin
          parse_ph = PH_IDLE;
          return 1'b1;
        end
        esc_next_byte = b;
        parse_ph = PH_FIRST;
        return 1'b0;
      end
      PH_FIRST: begin
        parse_ph = PH_IDLE;
        if (tmo) return 1'b1;
        if (esc_next_byte == ByteCsi) begin
          if (b >= ByteZero && b <= ByteNine) begin
            seq_digit = b;
            parse_ph = PH_DIGIT;
            return 1'b0;
          end
          key = csi_final_key(b);
        end else if (esc_next_byte == ByteSs3) begin
          if (b == "H") key = KeyHome;
          else if (b == "F") key = KeyEnd;
        end
      end
      PH_DIGIT: begin
        parse_ph = PH_IDLE;
        if (tmo) return 1'b1;
        if (b == ByteTilde) key = tilde_key(seq_digit);
      end
      default: begin
        parse_ph = PH_IDLE;
        if (tmo) return 1'b0;
        if (b == ByteEsc) begin
          parse_ph = PH_ESC;
          return 1'b0;
        end
        val = b;
        return 1'b1;
      end
    endcase
    if (key != KeyNone) begin
      spec = 1'b1;
      val  = {4'h0, key};
    end
    return 1'b1;
  endfunction

  task automatic add_item(input logic tmo, input logic [7:0] b);
    term_in_t it;
    it.timeout = tmo;
    it.data    = b;
    it.gap     = tx_calm ? 0 : pick_gap();
    it.drain   = drain_next;
    drain_next = 1'b0;
    pend_q.push_back(it);
  endtask

  task automatic add_byte(input logic [7:0] b);
    add_item(OpByte, b);
  endtask

  // byte lane carries junk on a timeout; the core must ignore it
  task automatic add_tmo();
    add_item(OpTimeout, 8'($urandom_range(255)));
  endtask

  // Slave-side driver: a transaction is predicted the moment it is accepted.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 8'h00;
      s_tuser  <= OpByte;
    end else begin
      if (s_tvalid && s_tready) begin
        if (decode_key(cur_item.timeout, cur_item.data, pred_spec, pred_val))
          key_q.push_back(key_res_t'{pred_spec, pred_val});
      end
      if (!s_tvalid || s_tready) begin
        // gaps are skipped while the master side holds off, to fill the core up
        if (gap_left != 0 && hold_left == 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (pend_q.size() != 0 && !(pend_q[0].drain && key_q.size() != 0)) begin
          cur_item = pend_q.pop_front();
          gap_left = cur_item.gap;
          s_tvalid <= 1'b1;
          s_tdata  <= cur_item.data;
          s_tuser  <= cur_item.timeout ? OpTimeout : OpByte;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Master-side monitor and ready generator.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (key_q.size() == 0) begin
          $error("unexpected result: is_special %0d key_value 0x%02h", m_tuser, m_tdata);
          failed = 1'b1;
        end else begin
          if (m_tuser !== key_q[0].special) begin
            $error("is_special: expected %0d, got %0d", key_q[0].special, m_tuser);
            failed = 1'b1;
          end
          if (m_tdata !== key_q[0].value) begin
            $error("key_value: expected 0x%02h, got 0x%02h", key_q[0].value, m_tdata);
            failed = 1'b1;
          end
          void'(key_q.pop_front());
        end
        results_seen++;
        if (results_seen == HOLD_AT) hold_left = HOLD_CYCLES;
        // a stretch of results taken without any stall
        rx_calm_done = (results_seen >= 500 && results_seen < 700);
      end
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (m_tvalid && m_tready && !rx_calm_done) stall_left = pick_gap();
      end
    end
  end

  // Watchdog: too long without any transaction means the core has hung.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    int unsigned n_rand;
    int unsigned sel;
    int unsigned k;

    // directed: byte extremes, idle timeout, every sequence form, abandoned sequences
    add_byte(8'h00);
    add_byte(8'hff);
    add_tmo();                                     // timeout while idle, no result
    add_byte(ByteEsc); add_byte(ByteCsi); add_byte("A");
    add_byte(ByteEsc); add_byte(ByteSs3); add_byte("F");
    add_byte(ByteEsc); add_byte(ByteCsi); add_byte("5"); add_byte(ByteTilde);
    add_byte(ByteEsc); add_byte(ByteCsi); add_byte("2"); add_byte(ByteTilde);  // no key
    add_byte(ByteEsc); add_byte(ByteCsi); add_byte("5"); add_byte("x");  // not a tilde
    add_byte(ByteEsc); add_tmo();                  // timeout inside a sequence
    add_byte(ByteEsc); add_byte(ByteEsc); add_byte(ByteEsc);  // ESC as a sequence byte
    add_byte(ByteEsc); add_byte(ByteSs3); add_byte("A");  // SS3 with unknown final

    // random: mostly well-formed sequences, the rest plain bytes, noise and broken ones
    drain_next = 1'b1;
    n_rand = 0;
    while (n_rand < RANDOM_BYTES) begin
      tx_calm = (n_rand >= 400 && n_rand < 550);
      if (n_rand >= 700 && n_rand < 704) drain_next = 1'b1;
      k = pend_q.size();
      sel = $urandom_range(99);
      if (sel < 25) begin
        add_byte(8'($urandom_range(255)));
      end else if (sel < 33) begin
        add_tmo();
      end else if (sel < 48) begin
        add_byte(ByteEsc); add_byte(ByteCsi); add_byte(CSI_FINALS[$urandom_range(5)]);
      end else if (sel < 55) begin
        add_byte(ByteEsc); add_byte(ByteSs3); add_byte($urandom_range(1) ? "H" : "F");
      end else if (sel < 75) begin
        add_byte(ByteEsc); add_byte(ByteCsi);
        add_byte(ByteZero + 8'($urandom_range(9))); add_byte(ByteTilde);
      end else if (sel < 85) begin
        add_byte(ByteEsc); add_byte(8'($urandom_range(255))); add_byte(8'($urandom_range(255)));
      end else if (sel < 92) begin
        add_byte(ByteEsc); add_byte(ByteCsi);
        add_byte(ByteZero + 8'($urandom_range(9))); add_byte(8'($urandom_range(255)));
      end else begin
        // sequence cut short by a timeout at a random depth
        add_byte(ByteEsc);
        sel = $urandom_range(2);
        if (sel >= 1) add_byte(ByteCsi);
        if (sel == 2) add_byte(ByteZero + 8'($urandom_range(9)));
        add_tmo();
      end
      n_rand += pend_q.size() - k;
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (pend_q.size() != 0 || s_tvalid || key_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (!failed) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
